@@ hw/rtl/mtx_pkg.sv @@
// Shared constants and control types for the MT19937 keystream XOR block.
package mtx_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int IDX_W        = $clog2(STATE_WORDS);
   localparam int TWIST_OFFSET = 397;
   localparam int WORD_W       = 32;
   localparam int DATA_W       = 8;

   localparam logic [WORD_W-1:0] LCG_MUL    = 32'h0001_0dcd;
   localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

   typedef enum logic [1:0] {
      RD_SEL_CUR = 2'd0,
      RD_SEL_NXT = 2'd1,
      RD_SEL_FAR = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       load_item;
      logic       seed_start;
      logic       seed_mul;
      logic       seed_write;
      rd_sel_type rd_sel;
      logic       cap_cur;
      logic       cap_nxt;
      logic       twist;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic seed_last;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/mtx_req_if.sv @@
// Input item channel: valid/ready handshake carrying one raw byte and its last flag.
interface mtx_req_if;
   import mtx_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_in;
   logic              last_in;

   modport source (output valid, output data_in, output last_in, input ready);
   modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

@@ hw/rtl/mtx_rsp_if.sv @@
// Result item channel: valid/ready handshake carrying one ciphered byte and its last flag.
interface mtx_rsp_if;
   import mtx_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic              last_out;

   modport source (output valid, output data_out, output last_out, input ready);
   modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

@@ hw/rtl/mtx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mtx_dpath.sv @@
// Datapath: seed register, LCG seeding, state table, on-the-fly twist, tempering, output register.
module mtx_dpath
   import mtx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic [DATA_W-1:0] req_data,
   input  logic              req_last,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_data,
   output logic              rsp_last
);

   logic [WORD_W-1:0] key_seed_ff, key_seed_in;
   logic [WORD_W-1:0] lcg_s_ff, lcg_s_in;
   logic [WORD_W-1:0] lcg_t_ff, lcg_t_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] cur_ff, cur_in;
   logic [WORD_W-1:0] nxt_ff, nxt_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [WORD_W-1:0] mul_a;
   logic [WORD_W-1:0] lcg_next;
   logic [IDX_W-1:0]  nxt_idx;
   logic [IDX_W:0]    far_sum;
   logic [IDX_W-1:0]  far_idx;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] twist_y;
   logic [WORD_W-1:0] twist_w;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] temp_a, temp_b, temp_c, temp_d;

   assign mul_a    = cmd.seed_write ? lcg_t_ff : lcg_s_ff;
   assign lcg_next = mul_a * LCG_MUL + 32'd1;

   assign nxt_idx = (idx_ff == IDX_W'(STATE_WORDS - 1)) ? '0 : idx_ff + 1'b1;
   assign far_sum = {1'b0, idx_ff} + (IDX_W + 1)'(TWIST_OFFSET);
   assign far_idx = (far_sum >= (IDX_W + 1)'(STATE_WORDS)) ?
                    IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_SEL_CUR: rd_addr = idx_ff;
         RD_SEL_NXT: rd_addr = nxt_idx;
         RD_SEL_FAR: rd_addr = far_idx;
         default:    rd_addr = idx_ff;
      endcase
   end

   assign twist_y = (cur_ff & UPPER_MASK) | (nxt_ff & LOWER_MASK);
   assign twist_w = rd_data ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);

   assign wr_en   = cmd.seed_write | cmd.twist;
   assign wr_data = cmd.seed_write ? {lcg_s_ff[31:16], lcg_t_ff[31:16]} : twist_w;

   mtx_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STATE_WORDS)
   ) u_words (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign temp_a = word_ff ^ (word_ff >> 11);
   assign temp_b = temp_a ^ ((temp_a << 7) & TEMPER_B);
   assign temp_c = temp_b ^ ((temp_b << 15) & TEMPER_C);
   assign temp_d = temp_c ^ (temp_c >> 18);

   always_comb begin
      key_seed_in  = csr_we ? csr_wdata : key_seed_ff;
      lcg_s_in     = lcg_s_ff;
      lcg_t_in     = lcg_t_ff;
      idx_in       = idx_ff;
      cur_in       = cmd.cap_cur ? rd_data : cur_ff;
      nxt_in       = cmd.cap_nxt ? rd_data : nxt_ff;
      word_in      = cmd.twist ? twist_w : word_ff;
      data_in      = cmd.load_item ? req_data : data_ff;
      last_in      = cmd.load_item ? req_last : last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.seed_start) begin
         lcg_s_in = key_seed_ff;
         idx_in   = '0;
      end
      if (cmd.seed_mul) begin
         lcg_t_in = lcg_next;
      end
      if (cmd.seed_write) begin
         lcg_s_in = lcg_next;
         idx_in   = nxt_idx;
      end
      if (cmd.twist) begin
         idx_in = nxt_idx;
      end
      if (cmd.load_out) begin
         rsp_data_in  = data_ff ^ temp_d[DATA_W-1:0];
         rsp_last_in  = last_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff  <= '0;
         lcg_s_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_seed_ff  <= key_seed_in;
         lcg_s_ff     <= lcg_s_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lcg_t_ff    <= lcg_t_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      word_ff     <= word_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.seed_last = (idx_ff == IDX_W'(STATE_WORDS - 1));
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

@@ hw/rtl/mtx_ctrl.sv @@
// Controller: sequences seeding, the three table reads, the twist write and the output load.
module mtx_ctrl
   import mtx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SEED_MUL = 8'b0000_0010,
      ST_SEED_WR  = 8'b0000_0100,
      ST_RD_CUR   = 8'b0000_1000,
      ST_RD_NXT   = 8'b0001_0000,
      ST_RD_FAR   = 8'b0010_0000,
      ST_TWIST    = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      seeded_ff, seeded_in;

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      cmd       = '0;
      cmd.rd_sel = RD_SEL_CUR;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (!seeded_ff) begin
                  cmd.seed_start = 1'b1;
                  state_in       = ST_SEED_MUL;
               end else begin
                  state_in = ST_RD_NXT;
               end
            end
         end
         ST_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            cmd.seed_write = 1'b1;
            if (status.seed_last) begin
               seeded_in = 1'b1;
               state_in  = ST_RD_CUR;
            end else begin
               state_in = ST_SEED_MUL;
            end
         end
         ST_RD_CUR: begin
            state_in = ST_RD_NXT;
         end
         ST_RD_NXT: begin
            cmd.cap_cur = 1'b1;
            cmd.rd_sel  = RD_SEL_NXT;
            state_in    = ST_RD_FAR;
         end
         ST_RD_FAR: begin
            cmd.cap_nxt = 1'b1;
            cmd.rd_sel  = RD_SEL_FAR;
            state_in    = ST_TWIST;
         end
         ST_TWIST: begin
            cmd.twist = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         seeded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

@@ hw/rtl/mt19937_keystream_xor_top.sv @@
// Top level of the MT19937 keystream XOR block: controller, datapath and checks.
// Once seeded, an item goes from acceptance through the three table reads, the twist and
// the output load, which waits for a free output slot; no new item is taken until then.
// The first item after reset or after a seed write first fills the table, with two LCG
// multiplies per word (SEED_MUL, SEED_WR), and then passes through the RD_CUR read state.
// Reset is synchronous, active high; it clears the seed, the index and the seeded flag.
module mt19937_keystream_xor_top
   import mtx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   mtx_req_if.sink           req_chan,
   mtx_rsp_if.source         rsp_chan
);

   cmd_type    cmd;
   status_type status;

   mtx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mtx_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_chan.data_in),
      .req_last  (req_chan.last_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_chan.data_out),
      .rsp_last  (rsp_chan.last_out)
   );

   a_load_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result loaded over an untaken result");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load_out))
      else $error("result valid without an output load");

   a_twist_after_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.twist |-> ($past(cmd.cap_nxt) && $past(cmd.cap_cur, 2)))
      else $error("twist without the current and next words read");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second item accepted while one is in progress");

endmodule
